/* rtl/core/olwd_pkg.sv */
// Shared types and codes for the ordered list block.
// Used by olwd_ctrl, olwd_datapath and ordered_list_with_deletes_top; no dependencies.
package olwd_pkg;

    localparam logic [2:0] REQ_APPEND    = 3'd0;
    localparam logic [2:0] REQ_DEL_FIRST = 3'd1;
    localparam logic [2:0] REQ_DEL_LAST  = 3'd2;
    localparam logic [2:0] REQ_DEL_VALUE = 3'd3;
    localparam logic [2:0] REQ_DUMP      = 3'd4;

    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_EMPTY     = 2'd1;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd2;
    localparam logic [1:0] OUT_FULL      = 2'd3;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_value;
    } in_word_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] element_value;
        logic [1:0]         outcome;
        logic               last_flag;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic exec;
        logic dump_step;
    } cmd_t;

    typedef struct packed {
        logic [2:0] in_req;
        logic       out_free;
        logic       dump_last;
    } status_t;

endpackage

/* rtl/core/olwd_ctrl.sv */
// Request sequencer for the ordered list block.
// Depends on olwd_pkg; drives the command word of olwd_datapath.
module olwd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  olwd_pkg::status_t status,
    output olwd_pkg::cmd_t    cmd
);

    olwd_pkg::state_t state_reg;
    olwd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olwd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olwd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (status.in_req)
                        olwd_pkg::REQ_DEL_VALUE: state_next = olwd_pkg::ST_MATCH;
                        olwd_pkg::REQ_DUMP:      state_next = olwd_pkg::ST_DUMP;
                        olwd_pkg::REQ_APPEND,
                        olwd_pkg::REQ_DEL_FIRST,
                        olwd_pkg::REQ_DEL_LAST:  state_next = olwd_pkg::ST_EXEC;
                        default:                 state_next = olwd_pkg::ST_IDLE;
                    endcase
                end
            end
            olwd_pkg::ST_MATCH: begin
                state_next = olwd_pkg::ST_EXEC;
            end
            olwd_pkg::ST_EXEC: begin
                if (status.out_free) begin
                    state_next = olwd_pkg::ST_IDLE;
                end
            end
            olwd_pkg::ST_DUMP: begin
                if (status.out_free && status.dump_last) begin
                    state_next = olwd_pkg::ST_IDLE;
                end
            end
            default: state_next = olwd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == olwd_pkg::ST_IDLE);
        cmd.capture   = (state_reg == olwd_pkg::ST_IDLE) && s_valid;
        cmd.match     = (state_reg == olwd_pkg::ST_MATCH);
        cmd.exec      = (state_reg == olwd_pkg::ST_EXEC) && status.out_free;
        cmd.dump_step = (state_reg == olwd_pkg::ST_DUMP) && status.out_free;
    end

endmodule

/* rtl/core/olwd_datapath.sv */
// Entry register file, compare vector, entry count and result register.
// Depends on olwd_pkg; sequenced by olwd_ctrl.
module olwd_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  olwd_pkg::in_word_t  s_data,
    input  logic                m_ready,
    output logic                m_valid,
    output olwd_pkg::out_word_t m_data,
    input  olwd_pkg::cmd_t      cmd,
    output olwd_pkg::status_t   status
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic signed [31:0]  entry_reg [LIST_DEPTH];
    logic signed [31:0]  entry_next [LIST_DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [2:0]          req_reg;
    logic signed [31:0]  operand_reg;
    logic [LIST_DEPTH-1:0] match_reg;
    logic [LIST_DEPTH-1:0] therm;
    logic [LIST_DEPTH-1:0] shift_mask;
    logic [IDX_W-1:0]    dump_idx_reg;
    logic                out_valid_reg;
    olwd_pkg::out_word_t out_word_reg;
    olwd_pkg::out_word_t out_word_next;

    logic count_zero;
    logic count_full;
    logic match_any;
    logic dump_last;
    logic do_append;
    logic do_shift;
    logic do_dec;
    logic do_rotate;

    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CNT_W'(LIST_DEPTH));
    assign match_any  = |match_reg;
    assign dump_last  = count_zero || ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);

    assign status.in_req    = s_data.req_type;
    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.dump_last = dump_last;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= s_data.req_type;
            operand_reg <= s_data.operand_value;
        end
    end

    // compare every live entry against the operand
    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                match_reg[i] <= (entry_reg[i] == operand_reg) &&
                                (CNT_W'(i) < count_reg);
            end
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_therm
        assign therm[g] = |match_reg[g:0];
    end

    always_comb begin
        do_append = 1'b0;
        do_shift  = 1'b0;
        do_dec    = 1'b0;
        shift_mask = therm;
        if (cmd.exec) begin
            case (req_reg)
                olwd_pkg::REQ_APPEND: begin
                    do_append = !count_full;
                end
                olwd_pkg::REQ_DEL_FIRST: begin
                    do_shift   = !count_zero;
                    do_dec     = !count_zero;
                    shift_mask = '1;
                end
                olwd_pkg::REQ_DEL_LAST: begin
                    do_dec = !count_zero;
                end
                olwd_pkg::REQ_DEL_VALUE: begin
                    do_shift = match_any;
                    do_dec   = match_any;
                end
                default: begin
                    do_append = 1'b0;
                end
            endcase
        end
    end

    assign do_rotate = cmd.dump_step && !count_zero;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_entry
        localparam int NXT = (g < LIST_DEPTH - 1) ? g + 1 : g;
        always_comb begin
            entry_next[g] = entry_reg[g];
            if (do_append && (CNT_W'(g) == count_reg)) begin
                entry_next[g] = operand_reg;
            end else if (do_shift && shift_mask[g] && (g < LIST_DEPTH - 1)) begin
                entry_next[g] = entry_reg[NXT];
            end else if (do_rotate) begin
                // wrap the head round to the tail
                if ((CNT_W'(g) + CNT_W'(1)) == count_reg) begin
                    entry_next[g] = entry_reg[0];
                end else if ((CNT_W'(g) + CNT_W'(1)) < count_reg) begin
                    entry_next[g] = entry_reg[NXT];
                end
            end
        end
        always_ff @(posedge aclk) begin
            entry_reg[g] <= entry_next[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (do_append) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (do_dec) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dump_idx_reg <= '0;
        end else if (cmd.dump_step) begin
            dump_idx_reg <= dump_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_word_next.result_kind   = olwd_pkg::KIND_STATUS;
        out_word_next.element_value = '0;
        out_word_next.outcome       = olwd_pkg::OUT_OK;
        out_word_next.last_flag     = 1'b1;
        if (cmd.dump_step) begin
            out_word_next.result_kind   = olwd_pkg::KIND_ELEMENT;
            out_word_next.element_value = count_zero ? '0 : entry_reg[0];
            out_word_next.outcome       = count_zero ? olwd_pkg::OUT_EMPTY : olwd_pkg::OUT_OK;
            out_word_next.last_flag     = dump_last;
        end else begin
            case (req_reg)
                olwd_pkg::REQ_APPEND: begin
                    out_word_next.outcome = count_full ? olwd_pkg::OUT_FULL : olwd_pkg::OUT_OK;
                end
                olwd_pkg::REQ_DEL_FIRST,
                olwd_pkg::REQ_DEL_LAST: begin
                    out_word_next.outcome = count_zero ? olwd_pkg::OUT_EMPTY : olwd_pkg::OUT_OK;
                end
                olwd_pkg::REQ_DEL_VALUE: begin
                    if (count_zero) begin
                        out_word_next.outcome = olwd_pkg::OUT_EMPTY;
                    end else if (!match_any) begin
                        out_word_next.outcome = olwd_pkg::OUT_NOT_FOUND;
                    end
                end
                default: begin
                    out_word_next.outcome = olwd_pkg::OUT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec || cmd.dump_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec || cmd.dump_step) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (req_reg == olwd_pkg::REQ_APPEND) && !count_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_word_reg.result_kind == olwd_pkg::KIND_STATUS))
        |-> (out_word_reg.element_value == '0) && out_word_reg.last_flag)
        else $error("status word carries element data");

endmodule

/* rtl/core/ordered_list_with_deletes_top.sv */
// Top level of the bounded ordered list with deletes.
// Depends on olwd_pkg, olwd_ctrl and olwd_datapath.
//
// Holds up to LIST_DEPTH signed 32-bit values in arrival order in a register file.
// One request is taken at a time: append, delete first and delete last are captured in
// the idle state and give their status word from the execute state, delete value
// passes through a parallel compare state first and then shifts to close the gap, and
// a dump gives one word per cycle while the downstream side accepts, entry_count words
// (one for an empty list) after the capture, as the dump rotates entries past the
// head register. A new request is taken in the cycle after the last word of the
// previous one is loaded into the output register. Requests with undefined codes
// are dropped silently.
module ordered_list_with_deletes_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olwd_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output olwd_pkg::out_word_t m_data
);

    olwd_pkg::cmd_t    cmd;
    olwd_pkg::status_t status;

    olwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    olwd_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule
